>>> rtl/core/kwh_pkg.sv
// Shared types, constants and helper functions for the k-mer window hasher.
package kwh_pkg;

  localparam int unsigned MAX_K_DEF = 32;
  localparam logic [7:0]  CASE_FOLD = 8'h5F;

  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

  localparam logic [1:0] CFG_KMER_LENGTH = 2'd0;
  localparam logic [1:0] CFG_HASH_SEED   = 2'd1;
  localparam logic [1:0] CFG_CANONICAL   = 2'd2;
  localparam logic [1:0] CFG_HASH_MODE   = 2'd3;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_STRIPE,
    ST_MERGE,
    ST_LANE8,
    ST_LANE4,
    ST_LANE1,
    ST_FINAL,
    ST_PICK,
    ST_OUT
  } kwh_state_t;

  // Datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_STRIPE,
    OP_MERGE,
    OP_LANE8,
    OP_LANE4,
    OP_LANE1,
    OP_FINAL,
    OP_PICK
  } kwh_op_t;

  typedef struct packed {
    kwh_op_t    op;
    logic [2:0] phase;   // sub-step within an operation
    logic       dir;     // 0 forward, 1 reverse complement
  } kwh_cmd_t;

  typedef struct packed {
    logic       long_key;   // k is 32: stripe path
    logic       lane8_left; // at least 8 bytes left
    logic       lane4_left; // at least 4 bytes left
    logic       lane1_left; // at least 1 byte left
    logic       step_done;  // current step completes at this edge
  } kwh_sts_t;

  function automatic logic [7:0] code_letter(input logic [1:0] c);
    unique case (c)
      2'd0:    code_letter = 8'h41;
      2'd1:    code_letter = 8'h43;
      2'd2:    code_letter = 8'h47;
      default: code_letter = 8'h54;
    endcase
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

endpackage

>>> rtl/core/kwh_datapath.sv
// Datapath: window state, byte buffer, shared 32x32 multiplier and hash accumulators.
module kwh_datapath #(
  parameter int unsigned MAX_K = kwh_pkg::MAX_K_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_symbol,
  input  logic              in_new_sequence,
  input  logic              take,
  output logic              has_result,
  input  logic [5:0]        kmer_length,
  input  logic [63:0]       hash_seed,
  input  logic              hash_mode,
  input  kwh_pkg::kwh_cmd_t cmd,
  output kwh_pkg::kwh_sts_t sts,
  output logic [63:0]       result
);
  import kwh_pkg::*;

  localparam int unsigned KW = $clog2(MAX_K + 1);

  logic [63:0]   win_r, win_nxt;
  logic [KW-1:0] run_r, run_nxt;
  logic [5:0]    k_eff;
  logic [7:0]    ch;
  logic [1:0]    code;
  logic          is_base;

  // Data registers
  logic [7:0]  buf_r [32];
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] v_r [4];
  logic [63:0] v_nxt [4];
  logic [63:0] t_r, t_nxt;
  logic [63:0] fwd_r, fwd_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] packed_r;

  logic [63:0] mul_a, mul_b, mul_p;
  logic [63:0] lane8, lane4;
  logic [1:0]  vi;

  // 64-bit product built from partial products on one 32x32 multiplier
  logic [1:0]  mc_r, mc_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] pm_a, pm_b;
  logic [63:0] pm_p;
  logic        uses_mul;
  logic        step_done;

  // Effective k: zero becomes one, clamp to MAX_K
  always_comb begin
    priority if (kmer_length == 6'd0) k_eff = 6'd1;
    else if (32'(kmer_length) > MAX_K) k_eff = 6'(MAX_K);
    else k_eff = kmer_length;
  end

  // Classify incoming symbol
  always_comb begin
    ch      = in_symbol & CASE_FOLD;
    is_base = 1'b1;
    code    = 2'd0;
    unique case (ch)
      8'h41:   code = 2'd0;
      8'h43:   code = 2'd1;
      8'h47:   code = 2'd2;
      8'h54:   code = 2'd3;
      default: is_base = 1'b0;
    endcase
  end

  // Advance window and run count
  always_comb begin
    logic [63:0] w;
    logic [KW-1:0] r;
    w = in_new_sequence ? 64'd0 : win_r;
    r = in_new_sequence ? '0 : run_r;
    win_nxt = {w[61:0], code & {2{is_base}}};
    if (!is_base) run_nxt = '0;
    else if (32'(r) < MAX_K) run_nxt = r + 1'b1;
    else run_nxt = r;
  end

  assign has_result = is_base && (32'(run_nxt) >= 32'(k_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      run_r <= '0;
    end else if (take) begin
      win_r <= win_nxt;
      run_r <= run_nxt;
    end
  end

  // Byte gathers from the buffer, little-endian
  always_comb begin
    lane8 = '0;
    lane4 = '0;
    for (int i = 0; i < 8; i++) lane8[8*i +: 8] = buf_r[5'(pos_r + 6'(i))];
    for (int i = 0; i < 4; i++) lane4[8*i +: 8] = buf_r[5'(pos_r + 6'(i))];
  end

  assign sts.long_key   = (k_eff == 6'd32);
  assign sts.lane8_left = (pos_r + 6'd8 <= k_eff) && (pos_r <= 6'd24);
  assign sts.lane4_left = (pos_r + 6'd4 <= k_eff) && (pos_r <= 6'd28);
  assign sts.lane1_left = (pos_r < k_eff);
  assign sts.step_done  = step_done;

  assign vi = cmd.phase[1:0];

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_STRIPE: begin
        if (!cmd.phase[2]) begin
          mul_a = lane8; mul_b = XP2;
        end else begin
          mul_a = t_r; mul_b = XP1;
        end
      end
      OP_MERGE: begin
        unique case (cmd.phase[1:0])
          2'd0: begin mul_a = v_r[0]; mul_b = XP2; end
          2'd1: begin mul_a = t_r; mul_b = XP1; end
          default: begin mul_a = t_r; mul_b = XP1; end
        endcase
      end
      OP_LANE8: begin
        unique case (cmd.phase[1:0])
          2'd0: begin mul_a = lane8; mul_b = XP2; end
          2'd1: begin mul_a = t_r; mul_b = XP1; end
          default: begin mul_a = t_r; mul_b = XP1; end
        endcase
      end
      OP_LANE4: begin
        mul_a = cmd.phase[0] ? t_r : lane4;
        mul_b = cmd.phase[0] ? XP2 : XP1;
      end
      OP_LANE1: begin
        mul_a = cmd.phase[0] ? t_r : {56'd0, buf_r[pos_r[4:0]]};
        mul_b = cmd.phase[0] ? XP1 : XP5;
      end
      OP_FINAL: begin
        mul_a = t_r;
        mul_b = (cmd.phase[1:0] == 2'd1) ? XP2 : XP3;
      end
      default: ;
    endcase
  end

  // Flag steps that need a product
  always_comb begin
    unique case (cmd.op)
      OP_STRIPE, OP_MERGE, OP_LANE8, OP_LANE4, OP_LANE1: uses_mul = 1'b1;
      OP_FINAL: uses_mul = (cmd.phase[1:0] != 2'd0);
      default:  uses_mul = 1'b0;
    endcase
  end

  // Pick one partial product of the low 64 bits per cycle
  always_comb begin
    unique case (mc_r)
      2'd1:    begin pm_a = mul_a[31:0];  pm_b = mul_b[63:32]; end
      2'd2:    begin pm_a = mul_a[63:32]; pm_b = mul_b[31:0];  end
      default: begin pm_a = mul_a[31:0];  pm_b = mul_b[31:0];  end
    endcase
  end

  // Upper operand halves are zero: a 32x32 multiply
  assign pm_p = {32'd0, pm_a} * {32'd0, pm_b};

  assign step_done = !uses_mul || (mc_r == 2'd2);
  assign mul_p     = acc_r + {pm_p[31:0], 32'd0};

  // Accumulate partial products; restart after the last one
  always_comb begin
    mc_nxt  = (uses_mul && mc_r != 2'd2) ? mc_r + 2'd1 : 2'd0;
    acc_nxt = (mc_r == 2'd0) ? pm_p : acc_r + {pm_p[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r  <= '0;
      acc_r <= '0;
    end else begin
      mc_r  <= mc_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Step the hash state
  always_comb begin
    pos_nxt = pos_r;
    h_nxt   = h_r;
    t_nxt   = t_r;
    fwd_nxt = fwd_r;
    res_nxt = res_r;
    for (int i = 0; i < 4; i++) v_nxt[i] = v_r[i];
    unique case (cmd.op)
      OP_INIT: begin
        pos_nxt  = '0;
        v_nxt[0] = hash_seed + XP1 + XP2;
        v_nxt[1] = hash_seed + XP2;
        v_nxt[2] = hash_seed;
        v_nxt[3] = hash_seed - XP1;
        h_nxt    = hash_seed + XP5 + 64'(k_eff);
      end
      // Stripe: lane in v[vi]; phase bit 2 selects multiply by XP1
      OP_STRIPE: begin
        if (!cmd.phase[2]) begin
          t_nxt = rotl(v_r[vi] + mul_p, 31);
        end else begin
          v_nxt[vi] = mul_p;
          pos_nxt   = pos_r + 6'd8;
          if (vi == 2'd3)
            h_nxt = rotl(v_r[0], 1) + rotl(v_r[1], 7) + rotl(v_r[2], 12)
                  + rotl(mul_p, 18);
        end
      end
      // Merge: rotate v up after each lane; phase 0,1,2
      OP_MERGE: begin
        unique case (cmd.phase[1:0])
          2'd0: t_nxt = rotl(mul_p, 31);
          2'd1: t_nxt = h_r ^ mul_p;
          default: begin
            h_nxt = mul_p + XP4;
            v_nxt[0] = v_r[1]; v_nxt[1] = v_r[2]; v_nxt[2] = v_r[3]; v_nxt[3] = v_r[0];
            if (cmd.phase[2]) h_nxt = mul_p + XP4 + 64'(k_eff);
          end
        endcase
      end
      OP_LANE8: begin
        unique case (cmd.phase[1:0])
          2'd0: t_nxt = rotl(mul_p, 31);
          2'd1: t_nxt = rotl(h_r ^ mul_p, 27);
          default: begin
            h_nxt   = mul_p + XP4;
            pos_nxt = pos_r + 6'd8;
          end
        endcase
      end
      OP_LANE4: begin
        if (!cmd.phase[0]) t_nxt = rotl(h_r ^ mul_p, 23);
        else begin
          h_nxt   = mul_p + XP3;
          pos_nxt = pos_r + 6'd4;
        end
      end
      OP_LANE1: begin
        if (!cmd.phase[0]) t_nxt = rotl(h_r ^ mul_p, 11);
        else begin
          h_nxt   = mul_p;
          pos_nxt = pos_r + 6'd1;
        end
      end
      OP_FINAL: begin
        unique case (cmd.phase[1:0])
          2'd0: t_nxt = h_r ^ (h_r >> 33);
          2'd1: t_nxt = mul_p ^ (mul_p >> 29);
          default: h_nxt = mul_p ^ (mul_p >> 32);
        endcase
      end
      OP_PICK: begin
        logic [63:0] val;
        val = hash_mode ? h_r : packed_r;
        if (!cmd.dir) begin
          fwd_nxt = val;
          res_nxt = val;
        end else begin
          res_nxt = (val < fwd_r) ? val : fwd_r;
        end
      end
      default: ;
    endcase
  end

  // Load letters and packed value for one direction
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      logic [63:0] pk;
      logic [1:0]  c;
      pk = '0;
      for (int i = 0; i < 32; i++) begin
        if (i < int'(k_eff)) begin
          if (cmd.dir) c = 2'd3 - win_r[2*i +: 2];
          else         c = win_r[2*(int'(k_eff) - 1 - i) +: 2];
          buf_r[i] <= code_letter(c);
          pk = {pk[61:0], c};
        end else begin
          buf_r[i] <= 8'h00;
        end
      end
      packed_r <= pk;
    end
  end

  // Update hash state once the current step completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      h_r   <= '0;
      t_r   <= '0;
      fwd_r <= '0;
      res_r <= '0;
      for (int i = 0; i < 4; i++) v_r[i] <= '0;
    end else if (step_done) begin
      pos_r <= pos_nxt;
      h_r   <= h_nxt;
      t_r   <= t_nxt;
      fwd_r <= fwd_nxt;
      res_r <= res_nxt;
      for (int i = 0; i < 4; i++) v_r[i] <= v_nxt[i];
    end
  end

  assign result = res_r;

`ifndef SYNTH
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_r) <= MAX_K) else $error("run count beyond MAX_K");
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_base) |=> (run_r == '0)) else $error("run not cleared on bad symbol");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 6'd32) else $error("byte position out of range");
`endif

endmodule

>>> rtl/core/kwh_ctrl.sv
// Controller: sequences load, XXH64 steps and result handover per item.
module kwh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              has_result,
  input  logic              canonical,
  input  logic              hash_mode,
  input  kwh_pkg::kwh_sts_t sts,
  output kwh_pkg::kwh_cmd_t cmd,
  output logic              take
);
  import kwh_pkg::*;

  kwh_state_t state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       dir_r, dir_nxt;
  logic [1:0] lane_r, lane_nxt;

  // Accept only while idle, or while handing over a result that leaves now
  assign in_stall = !(state_r == ST_IDLE || (state_r == ST_OUT && !out_stall));
  assign take     = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      dir_r   <= 1'b0;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      dir_r   <= dir_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    dir_nxt   = dir_r;
    lane_nxt  = lane_r;
    cmd.op    = OP_NONE;
    cmd.phase = ph_r;
    cmd.dir   = dir_r;
    unique case (state_r)
      ST_IDLE, ST_OUT: begin
        if (state_r == ST_OUT && out_stall) begin
          state_nxt = ST_OUT;
        end else if (take && has_result) begin
          state_nxt = ST_LOAD;
          dir_nxt   = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.op = OP_LOAD;
        ph_nxt = '0;
        state_nxt = hash_mode ? ST_INIT : ST_PICK;
      end
      ST_INIT: begin
        cmd.op   = OP_INIT;
        ph_nxt   = '0;
        lane_nxt = '0;
        state_nxt = sts.long_key ? ST_STRIPE : ST_LANE8;
      end
      // Four lanes, two steps each
      ST_STRIPE: begin
        cmd.op    = OP_STRIPE;
        cmd.phase = {ph_r[0], lane_r};
        if (ph_r[0]) begin
          ph_nxt = '0;
          lane_nxt = lane_r + 2'd1;
          if (lane_r == 2'd3) state_nxt = ST_MERGE;
        end else ph_nxt = 3'd1;
      end
      // Four merges, three steps each; last adds the length
      ST_MERGE: begin
        cmd.op    = OP_MERGE;
        cmd.phase = {(lane_r == 2'd3), ph_r[1:0]};
        if (ph_r[1:0] == 2'd2) begin
          ph_nxt = '0;
          lane_nxt = lane_r + 2'd1;
          if (lane_r == 2'd3) state_nxt = ST_LANE8;
        end else ph_nxt = ph_r + 3'd1;
      end
      ST_LANE8: begin
        if (!sts.lane8_left && ph_r == '0) begin
          state_nxt = ST_LANE4;
        end else begin
          cmd.op = OP_LANE8;
          ph_nxt = (ph_r == 3'd2) ? 3'd0 : ph_r + 3'd1;
        end
      end
      ST_LANE4: begin
        if (!sts.lane4_left && ph_r == '0) begin
          state_nxt = ST_LANE1;
        end else begin
          cmd.op = OP_LANE4;
          ph_nxt = ph_r[0] ? 3'd0 : 3'd1;
          if (ph_r[0]) state_nxt = ST_LANE1;
        end
      end
      ST_LANE1: begin
        if (!sts.lane1_left && ph_r == '0) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.op = OP_LANE1;
          ph_nxt = ph_r[0] ? 3'd0 : 3'd1;
        end
      end
      ST_FINAL: begin
        cmd.op = OP_FINAL;
        if (ph_r == 3'd2) begin
          ph_nxt = '0;
          state_nxt = ST_PICK;
        end else ph_nxt = ph_r + 3'd1;
      end
      ST_PICK: begin
        cmd.op = OP_PICK;
        if (canonical && !dir_r) begin
          dir_nxt = 1'b1;
          state_nxt = ST_LOAD;
        end else state_nxt = ST_OUT;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Hold the step until the datapath finishes its product
    if (!sts.step_done) begin
      state_nxt = state_r;
      ph_nxt    = ph_r;
      dir_nxt   = dir_r;
      lane_nxt  = lane_r;
    end
  end

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_OUT) |-> in_stall) else $error("took item while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped under stall");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (take && has_result) |=> (state_r == ST_LOAD)) else $error("result item not started");
`endif

endmodule

>>> rtl/core/kmer_window_hasher.sv
// Top level of the k-mer window hasher: configuration registers, controller and datapath.
// One character enters per transaction; a result appears when the last k symbols are all
// A/C/G/T. Items without a result leave the controller idle. A result item stalls the
// input through load and pick in packing mode, and again for the reverse direction in
// canonical mode; the next item is accepted while the result is handed over. In hash
// mode each direction runs from load through the XXH64 steps to pick, with stripe and
// merge rounds for k=32, and canonical mode runs both directions. The pace is set by the
// single shared 32x32 multiplier, which builds each 64-bit XXH64 product from three
// partial products, one round step at a time; a stalled result adds its own wait. Writes
// to the configuration registers must only be made while the block is idle.
module kmer_window_hasher #(
  parameter int unsigned MAX_K = kwh_pkg::MAX_K_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_symbol,
  input  logic        in_new_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_kmer_hash,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import kwh_pkg::*;

  logic [5:0]  kmer_length_r;
  logic [63:0] hash_seed_r;
  logic        canonical_r;
  logic        hash_mode_r;
  kwh_cmd_t    cmd;
  kwh_sts_t    sts;
  logic        take;
  logic        has_result;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= 6'd21;
      hash_seed_r   <= '0;
      canonical_r   <= 1'b0;
      hash_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KMER_LENGTH: kmer_length_r <= cfg_wdata[5:0];
        CFG_HASH_SEED:   hash_seed_r   <= cfg_wdata;
        CFG_CANONICAL:   canonical_r   <= cfg_wdata[0];
        CFG_HASH_MODE:   hash_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  kwh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .has_result, .canonical(canonical_r), .hash_mode(hash_mode_r),
    .sts, .cmd, .take
  );

  kwh_datapath #(.MAX_K(MAX_K)) u_dp (
    .clk, .rst_n, .in_symbol, .in_new_sequence, .take, .has_result,
    .kmer_length(kmer_length_r), .hash_seed(hash_seed_r),
    .hash_mode(hash_mode_r),
    .cmd, .sts, .result(out_kmer_hash)
  );

endmodule
